FILE: hdl/tbdeu_pkg.sv
// ----------------------------------------------------------------------------
// tbdeu_pkg
// Shared types and constants for the three-button debounce and event unit.
// ----------------------------------------------------------------------------
`default_nettype none

package tbdeu_pkg;

    localparam int CNT_W   = 8;
    localparam int EVENT_W = 10;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 8;

    // counter slots: any, up, down, select
    localparam int NUM_CNT = 4;

    localparam logic [CNT_W-1:0] RESET_RELEASE    = 8'd255;
    localparam logic [CNT_W-1:0] DEBOUNCE_RESET   = 8'd5;
    localparam logic [CNT_W-1:0] LONG_PRESS_RESET = 8'd200;
    localparam logic [CNT_W-1:0] LIMIT_RESET      = 8'd255;
    localparam logic             CLICK_EN_RESET   = 1'b1;

    typedef enum logic [1:0] {
        OP_TICK       = 2'd0,
        OP_CLR_EVENTS = 2'd1,
        OP_CLR_ALL    = 2'd2,
        OP_ARM_IGNORE = 2'd3
    } t_opcode;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DEBOUNCE   = 3'd0,
        CFG_LONG_PRESS = 3'd1,
        CFG_LIMIT      = 3'd2,
        CFG_CLICK_EN   = 3'd3
    } t_cfg_idx;

    // event flag bit positions
    localparam int EV_ANY_P = 0;
    localparam int EV_ANY_R = 1;
    localparam int EV_ANY_L = 2;
    localparam int EV_UP_P  = 3;
    localparam int EV_UP_R  = 4;
    localparam int EV_DN_P  = 5;
    localparam int EV_DN_R  = 6;
    localparam int EV_SEL_P = 7;
    localparam int EV_SEL_R = 8;
    localparam int EV_SEL_L = 9;

endpackage

`default_nettype wire

FILE: hdl/three_button_debounce_event_unit_core.sv
// ----------------------------------------------------------------------------
// three_button_debounce_event_unit_core
// Debounces up, down and select, keeps saturating pressed/released counters
// and raises sticky press, release and long-press events.
// ----------------------------------------------------------------------------
//  channel   direction  handshake                 payload
//  in        in         i_in_valid / o_in_ready   opcode, up/down/select level
//  out       out        o_out_valid / i_out_ready event flags, any event,
//                                                 click, ignore pending
//  cfg       in         i_cfg_valid / o_cfg_ready register index, data
//
//  One word per cycle sustained while the output is not stalled: an accepted
//  word sits in the input register, then one pass of compare-and-count logic
//  updates the state and loads the result register.
//  A stalled output holds the result register and, behind it, the input
//  register; a new word is still taken whenever the input register drains.
//  Reset is synchronous; it restores all counters, flags, valids and config.
// ----------------------------------------------------------------------------
`default_nettype none

module three_button_debounce_event_unit_core
    import tbdeu_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,

    input  wire logic                  i_in_valid,
    output logic                       o_in_ready,
    input  wire logic [1:0]            i_opcode,
    input  wire logic                  i_up_level,
    input  wire logic                  i_down_level,
    input  wire logic                  i_select_level,

    output logic                       o_out_valid,
    input  wire logic                  i_out_ready,
    output logic [EVENT_W-1:0]         o_event_flags,
    output logic                       o_any_event,
    output logic                       o_key_click,
    output logic                       o_ignore_pending,

    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    // configuration
    logic [CNT_W-1:0] r_debounce;
    logic [CNT_W-1:0] r_long_press;
    logic [CNT_W-1:0] r_limit;
    logic             r_click_en;

    // input register
    logic             r_in_valid;
    t_opcode          r_op;
    logic [NUM_CNT-1:0] r_levels;

    // result register
    logic               r_out_valid;
    logic [EVENT_W-1:0] r_out_flags;
    logic               r_out_any;
    logic               r_out_click;
    logic               r_out_ignore;

    // state
    logic [CNT_W-1:0]   r_press [NUM_CNT];
    logic [CNT_W-1:0]   r_rel   [NUM_CNT];
    logic [EVENT_W-1:0] r_events;
    logic               r_any_flag;
    logic               r_ign_release;
    logic               r_ign_next;

    logic [CNT_W-1:0]   n_press [NUM_CNT];
    logic [CNT_W-1:0]   n_rel   [NUM_CNT];
    logic [EVENT_W-1:0] n_events;
    logic               n_any_flag;
    logic               n_ign_release;
    logic               n_ign_next;
    logic               n_click;

    // counter values after one tick of counting
    logic [CNT_W-1:0]   c_press [NUM_CNT];
    logic [CNT_W-1:0]   c_rel   [NUM_CNT];
    logic [EVENT_W-1:0] hits;
    logic               advance;
    logic               blocked;

    assign advance     = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || advance;
    assign o_cfg_ready = 1'b1;

    always_comb begin
        for (int g = 0; g < NUM_CNT; g++) begin
            c_press[g] = r_press[g];
            c_rel[g]   = r_rel[g];
            if (r_levels[g] && (r_press[g] < r_limit)) begin
                c_press[g] = r_press[g] + 1'b1;
                c_rel[g]   = '0;
            end else if (!r_levels[g] && (r_rel[g] < r_limit)) begin
                c_rel[g]   = r_rel[g] + 1'b1;
                c_press[g] = '0;
            end
        end
    end

    always_comb begin
        hits           = '0;
        hits[EV_ANY_P] = (c_press[0] == r_debounce);
        hits[EV_ANY_R] = (c_rel[0]   == r_debounce);
        hits[EV_ANY_L] = (c_press[0] == r_long_press);
        hits[EV_UP_P]  = (c_press[1] == r_debounce);
        hits[EV_UP_R]  = (c_rel[1]   == r_debounce);
        hits[EV_DN_P]  = (c_press[2] == r_debounce);
        hits[EV_DN_R]  = (c_rel[2]   == r_debounce);
        hits[EV_SEL_P] = (c_press[3] == r_debounce);
        hits[EV_SEL_R] = (c_rel[3]   == r_debounce);
        hits[EV_SEL_L] = (c_press[3] == r_long_press);
    end

    // a press while ignore-until-release is armed only bumps the any counter and marks the next event for flushing
    assign blocked = r_levels[0] && r_ign_release;

    always_comb begin
        n_press       = r_press;
        n_rel         = r_rel;
        n_events      = r_events;
        n_any_flag    = r_any_flag;
        n_ign_release = r_ign_release;
        n_ign_next    = r_ign_next;
        n_click       = 1'b0;
        case (r_op)
            OP_TICK: begin
                n_press[0] = c_press[0];
                n_rel[0]   = c_rel[0];
                if (blocked) begin
                    n_ign_next = 1'b1;
                end else begin
                    n_ign_release = 1'b0;
                    n_press       = c_press;
                    n_rel         = c_rel;
                    n_events      = r_events | hits;
                    n_any_flag    = r_any_flag | (|hits);
                    n_click       = hits[EV_ANY_P] && r_click_en;
                    // flush the event that follows an ignored press
                    if (n_any_flag && r_ign_next) begin
                        n_events   = '0;
                        n_any_flag = 1'b0;
                        n_ign_next = 1'b0;
                    end
                end
            end
            OP_CLR_EVENTS: begin
                n_events   = '0;
                n_any_flag = 1'b0;
                n_ign_next = 1'b0;
            end
            OP_CLR_ALL: begin
                for (int i = 1; i < NUM_CNT; i++) begin
                    n_press[i] = '0;
                end
                for (int i = 0; i < NUM_CNT; i++) begin
                    n_rel[i] = RESET_RELEASE;
                end
                n_ign_release = 1'b0;
                n_events      = '0;
                n_any_flag    = 1'b0;
                n_ign_next    = 1'b0;
            end
            OP_ARM_IGNORE: begin
                n_ign_release = 1'b1;
            end
            default: begin
                n_ign_next = r_ign_next;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce   <= DEBOUNCE_RESET;
            r_long_press <= LONG_PRESS_RESET;
            r_limit      <= LIMIT_RESET;
            r_click_en   <= CLICK_EN_RESET;
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_DEBOUNCE:   r_debounce   <= i_cfg_data;
                CFG_LONG_PRESS: r_long_press <= i_cfg_data;
                CFG_LIMIT:      r_limit      <= i_cfg_data;
                CFG_CLICK_EN:   r_click_en   <= i_cfg_data[0];
                default: begin
                    r_click_en <= r_click_en;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid    <= 1'b0;
            r_out_valid   <= 1'b0;
            r_events      <= '0;
            r_any_flag    <= 1'b0;
            r_ign_release <= 1'b0;
            r_ign_next    <= 1'b0;
            for (int i = 0; i < NUM_CNT; i++) begin
                r_press[i] <= '0;
                r_rel[i]   <= RESET_RELEASE;
            end
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (advance) begin
                r_out_valid   <= 1'b1;
                r_press       <= n_press;
                r_rel         <= n_rel;
                r_events      <= n_events;
                r_any_flag    <= n_any_flag;
                r_ign_release <= n_ign_release;
                r_ign_next    <= n_ign_next;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_op     <= t_opcode'(i_opcode);
            r_levels <= {i_select_level, i_down_level, i_up_level,
                         i_up_level | i_down_level | i_select_level};
        end
        if (advance) begin
            r_out_flags  <= n_events;
            r_out_any    <= n_any_flag;
            r_out_click  <= n_click;
            r_out_ignore <= n_ign_release | n_ign_next;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_event_flags    = r_out_flags;
    assign o_any_event      = r_out_any;
    assign o_key_click      = r_out_click;
    assign o_ignore_pending = r_out_ignore;

endmodule

`default_nettype wire

FILE: tb/sv/debounce_event_checker.sv
// ----------------------------------------------------------------------------
// debounce_event_checker
// Watches the input, output and register channels of the debounce and event
// unit, keeps its own copy of the counters, flags and registers, and checks
// every result word against the predicted button status, field by field.
// ----------------------------------------------------------------------------
module debounce_event_checker
    import tbdeu_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,

    input  logic                  i_in_valid,
    input  logic                  i_in_ready,
    input  logic [1:0]            i_opcode,
    input  logic                  i_up_level,
    input  logic                  i_down_level,
    input  logic                  i_select_level,

    input  logic                  i_out_valid,
    input  logic                  i_out_ready,
    input  logic [EVENT_W-1:0]    i_event_flags,
    input  logic                  i_any_event,
    input  logic                  i_key_click,
    input  logic                  i_ignore_pending,

    input  logic                  i_cfg_valid,
    input  logic                  i_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,

    output int                    o_pending,
    output int                    o_mismatches
);

    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic [EVENT_W-1:0] flags;
        logic               any_event;
        logic               click;
        logic               ign_pending;
    } t_button_status;

    // register copies
    logic [CNT_W-1:0]   db_period;
    logic [CNT_W-1:0]   lp_period;
    logic [CNT_W-1:0]   cnt_limit;
    logic               click_en;

    // slot 0 is any button, then up, down, select
    logic [CNT_W-1:0]   press_cnt [NUM_CNT];
    logic [CNT_W-1:0]   rel_cnt   [NUM_CNT];
    logic [EVENT_W-1:0] ev_bits;
    logic               any_ev;
    logic               ign_until_rel;
    logic               ign_next;

    t_button_status     status_q [$];
    int                 mismatch_count = 0;

    function automatic void reset_model();
        db_period = DEBOUNCE_RESET;
        lp_period = LONG_PRESS_RESET;
        cnt_limit = LIMIT_RESET;
        click_en  = CLICK_EN_RESET;
        for (int i = 0; i < NUM_CNT; i++) begin
            press_cnt[i] = '0;
            rel_cnt[i]   = RESET_RELEASE;
        end
        ev_bits       = '0;
        any_ev        = 1'b0;
        ign_until_rel = 1'b0;
        ign_next      = 1'b0;
    endfunction

    function automatic void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        case (idx)
            CFG_DEBOUNCE:   db_period = data;
            CFG_LONG_PRESS: lp_period = data;
            CFG_LIMIT:      cnt_limit = data;
            CFG_CLICK_EN:   click_en  = data[0];
            default: ;
        endcase
    endfunction

    function automatic void set_event(int pos);
        ev_bits[pos] = 1'b1;
        any_ev       = 1'b1;
    endfunction

    function automatic void drop_events();
        ev_bits  = '0;
        any_ev   = 1'b0;
        ign_next = 1'b0;
    endfunction

    function automatic void count_button(int idx, logic lvl, int ev_p, int ev_r);
        if (lvl && press_cnt[idx] < cnt_limit) begin
            press_cnt[idx] = press_cnt[idx] + 1'b1;
            rel_cnt[idx]   = '0;
        end
        if (!lvl && rel_cnt[idx] < cnt_limit) begin
            rel_cnt[idx]   = rel_cnt[idx] + 1'b1;
            press_cnt[idx] = '0;
        end
        if (press_cnt[idx] == db_period)
            set_event(ev_p);
        if (rel_cnt[idx] == db_period)
            set_event(ev_r);
    endfunction

    // one tick; returns the click pulse
    function automatic logic run_tick(logic up, logic dn, logic sel);
        logic pressed;
        logic pulse;
        pressed = up | dn | sel;
        pulse   = 1'b0;
        if (pressed && press_cnt[0] < cnt_limit) begin
            press_cnt[0] = press_cnt[0] + 1'b1;
            rel_cnt[0]   = '0;
        end
        // still held after arming: swallow the tick, flush the next event
        if (pressed && ign_until_rel) begin
            ign_next = 1'b1;
            return 1'b0;
        end
        ign_until_rel = 1'b0;
        if (!pressed && rel_cnt[0] < cnt_limit) begin
            rel_cnt[0]   = rel_cnt[0] + 1'b1;
            press_cnt[0] = '0;
        end
        if (press_cnt[0] == lp_period)
            set_event(EV_ANY_L);
        if (press_cnt[0] == db_period) begin
            set_event(EV_ANY_P);
            pulse = click_en;
        end
        if (rel_cnt[0] == db_period)
            set_event(EV_ANY_R);
        count_button(1, up,  EV_UP_P,  EV_UP_R);
        count_button(2, dn,  EV_DN_P,  EV_DN_R);
        count_button(3, sel, EV_SEL_P, EV_SEL_R);
        if (press_cnt[3] == lp_period)
            set_event(EV_SEL_L);
        // click survives the flush on the same tick
        if (any_ev && ign_next)
            drop_events();
        return pulse;
    endfunction

    function automatic t_button_status next_status(logic [1:0] op, logic up, logic dn,
                                                   logic sel);
        t_button_status st;
        logic           pulse;
        pulse = 1'b0;
        case (op)
            OP_TICK:       pulse = run_tick(up, dn, sel);
            OP_CLR_EVENTS: drop_events();
            OP_CLR_ALL: begin
                // any-pressed counter is kept
                for (int i = 1; i < NUM_CNT; i++)
                    press_cnt[i] = '0;
                for (int i = 0; i < NUM_CNT; i++)
                    rel_cnt[i] = RESET_RELEASE;
                ign_until_rel = 1'b0;
                drop_events();
            end
            default:       ign_until_rel = 1'b1;
        endcase
        st.flags       = ev_bits;
        st.any_event   = any_ev;
        st.click       = pulse;
        st.ign_pending = ign_until_rel | ign_next;
        return st;
    endfunction

    function automatic void check_field(string name, logic [EVENT_W-1:0] want,
                                        logic [EVENT_W-1:0] seen);
        if (seen !== want) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT)
                $display("mismatch on %s: expected %0h, got %0h", name, want, seen);
        end
    endfunction

    always @(posedge i_clk) begin
        t_button_status seen;
        t_button_status want;
        if (!i_rst_n) begin
            reset_model();
            status_q.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready)
                write_reg(i_cfg_index, i_cfg_data);
            if (i_out_valid && i_out_ready) begin
                seen.flags       = i_event_flags;
                seen.any_event   = i_any_event;
                seen.click       = i_key_click;
                seen.ign_pending = i_ignore_pending;
                if (status_q.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT)
                        $display("unexpected result word: flags %0h", seen.flags);
                end else begin
                    want = status_q.pop_front();
                    check_field("event_flags", want.flags, seen.flags);
                    check_field("any_event", EVENT_W'(want.any_event),
                                EVENT_W'(seen.any_event));
                    check_field("key_click", EVENT_W'(want.click), EVENT_W'(seen.click));
                    check_field("ignore_pending", EVENT_W'(want.ign_pending),
                                EVENT_W'(seen.ign_pending));
                end
            end
            if (i_in_valid && i_in_ready)
                status_q.push_back(next_status(i_opcode, i_up_level, i_down_level,
                                               i_select_level));
        end
        o_pending    <= status_q.size();
        o_mismatches <= mismatch_count;
    end

endmodule

FILE: tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Drives the debounce and event unit with directed button sequences and
// random press/hold/release traffic under several register settings, with
// random stalls on both channels; the checker beside the block does the
// predicting and comparing, this module gives the verdict.
// ----------------------------------------------------------------------------
module tb;
    import tbdeu_pkg::*;

    localparam int NUM_REGS       = 4;
    localparam int SETTLE_CYCLES  = 4;
    localparam int DRAIN_CYCLES   = 8;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int HOLD_OFF       = 80;

    // level bits: up, down, select
    localparam logic [2:0] LV_NONE = 3'b000;
    localparam logic [2:0] LV_UP   = 3'b001;
    localparam logic [2:0] LV_DN   = 3'b010;
    localparam logic [2:0] LV_SEL  = 3'b100;
    localparam logic [2:0] LV_ALL  = 3'b111;

    logic                  i_clk          = 1'b0;
    logic                  i_rst_n        = 1'b0;
    logic                  i_in_valid     = 1'b0;
    logic [1:0]            i_opcode       = OP_TICK;
    logic                  i_up_level     = 1'b0;
    logic                  i_down_level   = 1'b0;
    logic                  i_select_level = 1'b0;
    logic                  i_out_ready    = 1'b0;
    logic                  i_cfg_valid    = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index    = CFG_DEBOUNCE;
    logic [CFG_DATA_W-1:0] i_cfg_data     = '0;

    logic                  o_in_ready;
    logic                  o_out_valid;
    logic [EVENT_W-1:0]    o_event_flags;
    logic                  o_any_event;
    logic                  o_key_click;
    logic                  o_ignore_pending;
    logic                  o_cfg_ready;

    int pending;
    int mismatches;
    int tx_gap_max  = 3;
    int rx_gap_max  = 3;
    int rx_hold     = 0;
    int idle_cycles = 0;

    three_button_debounce_event_unit_core dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_opcode         (i_opcode),
        .i_up_level       (i_up_level),
        .i_down_level     (i_down_level),
        .i_select_level   (i_select_level),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_event_flags    (o_event_flags),
        .o_any_event      (o_any_event),
        .o_key_click      (o_key_click),
        .o_ignore_pending (o_ignore_pending),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data)
    );

    debounce_event_checker u_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .i_in_ready       (o_in_ready),
        .i_opcode         (i_opcode),
        .i_up_level       (i_up_level),
        .i_down_level     (i_down_level),
        .i_select_level   (i_select_level),
        .i_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .i_event_flags    (o_event_flags),
        .i_any_event      (o_any_event),
        .i_key_click      (o_key_click),
        .i_ignore_pending (o_ignore_pending),
        .i_cfg_valid      (i_cfg_valid),
        .i_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .o_pending        (pending),
        .o_mismatches     (mismatches)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // no handshake of any kind for too long: hung
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    // result side: random stalls, plus one long hold-off on request
    initial begin
        int w;
        forever begin
            if (rx_hold > 0) begin
                w       = rx_hold;
                rx_hold = 0;
            end else begin
                w = $urandom_range(0, rx_gap_max);
            end
            if (w > 0) begin
                i_out_ready <= 1'b0;
                repeat (w) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!(o_out_valid && i_out_ready));
        end
    end

    task automatic send_word(input t_opcode op, input logic [2:0] lv);
        int gap;
        gap = $urandom_range(0, tx_gap_max);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_opcode       <= op;
        i_up_level     <= lv[0];
        i_down_level   <= lv[1];
        i_select_level <= lv[2];
        do @(posedge i_clk); while (!(i_in_valid && o_in_ready));
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!(i_cfg_valid && o_cfg_ready));
    endtask

    task automatic set_regs(input int db, input int lp, input int lim, input logic ce);
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        // an index past the register list must be ignored
        put_reg(CFG_IDX_W'($urandom_range(NUM_REGS, 2**CFG_IDX_W - 1)), CFG_DATA_W'($urandom));
        put_reg(CFG_DEBOUNCE,   CFG_DATA_W'(db));
        put_reg(CFG_LONG_PRESS, CFG_DATA_W'(lp));
        put_reg(CFG_LIMIT,      CFG_DATA_W'(lim));
        put_reg(CFG_CLICK_EN,   {7'($urandom), ce});
        i_cfg_valid <= 1'b0;
    endtask

    // mostly held levels of random length, some bounces, noise and commands
    task automatic run_phase(input int budget, input int db, input int hold_cap,
                             input bit squeeze);
        int          sent;
        int          kind;
        int          dur;
        bit          squeezed;
        logic [2:0]  lv;
        sent     = 0;
        squeezed = 1'b0;
        while (sent < budget) begin
            if (squeeze && !squeezed && sent > budget / 2) begin
                rx_hold  = HOLD_OFF;
                squeezed = 1'b1;
            end
            kind = $urandom_range(0, 99);
            if (kind < 6) begin
                send_word(t_opcode'($urandom_range(OP_CLR_EVENTS, OP_ARM_IGNORE)), 3'($urandom));
                sent++;
            end else if (kind < 14) begin
                dur = $urandom_range(1, 8);
                repeat (dur) begin
                    send_word(OP_TICK, 3'($urandom));
                    sent++;
                end
            end else begin
                lv  = 3'($urandom);
                dur = (kind < 30) ? $urandom_range(1, db) : $urandom_range(1, hold_cap);
                repeat (dur) begin
                    send_word(OP_TICK, lv);
                    sent++;
                end
            end
        end
    endtask

    initial begin
        int db;
        int lp;
        int lim;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // power-up register values
        send_word(OP_TICK, LV_NONE);
        send_word(OP_CLR_ALL, LV_ALL);
        send_word(OP_TICK, LV_ALL);

        set_regs(2, 4, 6, 1'b1);
        repeat (2) send_word(OP_TICK, LV_UP);
        send_word(OP_TICK, LV_UP | LV_DN);
        repeat (2) send_word(OP_TICK, LV_ALL);
        // arm while held, release, then a click on the tick that flushes
        send_word(OP_CLR_EVENTS, LV_ALL);
        send_word(OP_ARM_IGNORE, LV_NONE);
        send_word(OP_TICK, LV_SEL);
        send_word(OP_TICK, LV_NONE);
        repeat (2) send_word(OP_TICK, LV_UP);
        send_word(OP_TICK, LV_DN);
        repeat (2) send_word(OP_TICK, LV_NONE);
        send_word(OP_CLR_ALL, LV_NONE);
        // select held into long press and saturation
        repeat (6) send_word(OP_TICK, LV_SEL);

        // zero periods match idle counters; limit below the counter values
        set_regs(0, 0, 1, 1'b0);
        send_word(OP_TICK, LV_NONE);
        send_word(OP_TICK, LV_ALL);
        send_word(OP_ARM_IGNORE, LV_UP);
        send_word(OP_TICK, LV_NONE);

        set_regs(1, 1, 1, 1'b1);
        run_phase(150, 1, 4, 1'b0);

        set_regs(255, 255, 255, 1'b0);
        run_phase(600, 255, 300, 1'b0);

        for (int p = 0; p < 6; p++) begin
            db  = $urandom_range(1, 8);
            lp  = $urandom_range(db, 40);
            lim = $urandom_range(2, 60);
            tx_gap_max = (p % 3 == 1) ? 0 : 3;
            rx_gap_max = tx_gap_max;
            set_regs(db, lp, lim, 1'($urandom));
            run_phase(190, db, lp + 6, p == 2);
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
